FILE: hdl/tfd_pkg.sv
package tfd_pkg;

  localparam int unsigned KindW  = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 32;

  // Frame type codes
  localparam logic [KindW-1:0] KIND_NONE  = 4'd0;
  localparam logic [KindW-1:0] KIND_EMPTY = 4'd1;
  localparam logic [KindW-1:0] KIND_SHORT = 4'd2;
  localparam logic [KindW-1:0] KIND_QUAD  = 4'd3;
  localparam logic [KindW-1:0] KIND_LONG  = 4'd8;

  // Fixed payload sizes
  localparam logic [CountW-1:0] SIZE_SHORT = 32'd1;
  localparam logic [CountW-1:0] SIZE_QUAD  = 32'd4;
  localparam logic [CountW-1:0] SIZE_LONG  = 32'd24;

  localparam logic [1:0] LEN_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_TYPE = 2'd0,
    ROLE_LEN  = 2'd1,
    ROLE_PAY  = 2'd2,
    ROLE_REJ  = 2'd3
  } role_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    role_e            role;
    logic             fend;
    logic             bad;
  } result_t;

  typedef struct packed {
    logic   halted;
    phase_e phase;
  } status_t;

endpackage

FILE: hdl/tfd_parse.sv
module tfd_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [tfd_pkg::ByteW-1:0]   rx_byte_i,
  output tfd_pkg::result_t            result_o,
  output tfd_pkg::status_t            status_o
);
  import tfd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [1:0]         len_idx_q, len_idx_d;
  logic [CountW-1:0]  left_q, left_d;
  logic               halted_q, halted_d;
  logic [CountW-1:0]  shifted;
  logic [CountW-1:0]  dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      kind_q    <= KIND_NONE;
      len_idx_q <= 2'd0;
      left_q    <= '0;
      halted_q  <= 1'b0;
    end else if (push_i) begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      len_idx_q <= len_idx_d;
      left_q    <= left_d;
      halted_q  <= halted_d;
    end
  end

  assign shifted = {left_q[CountW-ByteW-1:0], rx_byte_i};
  assign dec     = (left_q != '0) ? left_q - CountW'(1) : left_q;

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    len_idx_d = len_idx_q;
    left_d    = left_q;
    halted_d  = halted_q;

    result_o.kind = KIND_NONE;
    result_o.data = rx_byte_i;
    result_o.role = ROLE_REJ;
    result_o.fend = 1'b0;
    result_o.bad  = 1'b0;

    if (halted_q) begin
      result_o.bad = 1'b1;
    end else begin
      case (phase_q)
        PH_TYPE: begin
          if (rx_byte_i == ByteW'(KIND_EMPTY)) begin
            result_o.kind = KIND_EMPTY;
            result_o.role = ROLE_TYPE;
            result_o.fend = 1'b1;
          end else if (rx_byte_i inside {8'd2, 8'd3, 8'd8}) begin
            result_o.kind = rx_byte_i[KindW-1:0];
            result_o.role = ROLE_TYPE;
            kind_d        = rx_byte_i[KindW-1:0];
            phase_d       = PH_PAY;
            if (rx_byte_i == ByteW'(KIND_SHORT)) begin
              left_d = SIZE_SHORT;
            end else if (rx_byte_i == ByteW'(KIND_QUAD)) begin
              left_d = SIZE_QUAD;
            end else begin
              left_d = SIZE_LONG;
            end
          end else if (rx_byte_i inside {[8'd4:8'd7]}) begin
            result_o.kind = rx_byte_i[KindW-1:0];
            result_o.role = ROLE_TYPE;
            kind_d        = rx_byte_i[KindW-1:0];
            len_idx_d     = 2'd0;
            left_d        = '0;
            phase_d       = PH_LEN;
          end else begin
            // Unknown type: stop here until reset
            halted_d     = 1'b1;
            result_o.bad = 1'b1;
          end
        end
        PH_LEN: begin
          result_o.kind = kind_q;
          result_o.role = ROLE_LEN;
          left_d        = shifted;
          if (len_idx_q == LEN_LAST) begin
            len_idx_d = 2'd0;
            if (shifted == '0) begin
              result_o.fend = 1'b1;
              phase_d       = PH_TYPE;
            end else begin
              phase_d = PH_PAY;
            end
          end else begin
            len_idx_d = len_idx_q + 2'd1;
          end
        end
        PH_PAY: begin
          result_o.kind = kind_q;
          result_o.role = ROLE_PAY;
          left_d        = dec;
          if (dec == '0) begin
            result_o.fend = 1'b1;
            phase_d       = PH_TYPE;
          end
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
    end
  end

  assign status_o.halted = halted_q;
  assign status_o.phase  = phase_q;

endmodule

FILE: hdl/tfd_skid.sv
module tfd_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tfd_pkg::result_t  data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output tfd_pkg::result_t  data_o
);
  import tfd_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop = main_valid_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  // Payload: refill main from skid on a pop, else park the new word
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

FILE: hdl/typed_frame_deframer.sv
// Typed frame deframer: splits a byte stream into frames led by a type byte
// (type 1 empty, 2/3/8 fixed payloads of 1/4/24 bytes, 4..7 a 4-byte
// big-endian length then that many payload bytes) and returns one word per
// input byte, tagged with frame type, role and frame end. One byte is taken
// every clock while the output buffer is not full; each result is registered
// in a two-entry output buffer, which keeps input flowing while the output
// stalls until its second entry fills. An unknown type byte sets bad_type_o
// and halts parsing until reset; every later byte is echoed as rejected.
module typed_frame_deframer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tfd_pkg::ByteW-1:0]         rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tfd_pkg::KindW-1:0]         frame_kind_o,
  output logic [tfd_pkg::ByteW-1:0]         data_byte_o,
  output logic [1:0]                        byte_role_o,
  output logic                              frame_end_o,
  output logic                              bad_type_o
);
  import tfd_pkg::*;

  logic    push;
  logic    full;
  result_t result;
  result_t out_word;
  status_t status;

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  tfd_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rx_byte_i (rx_byte_i),
    .result_o  (result),
    .status_o  (status)
  );

  tfd_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_word)
  );

  assign frame_kind_o = out_word.kind;
  assign data_byte_o  = out_word.data;
  assign byte_role_o  = out_word.role;
  assign frame_end_o  = out_word.fend;
  assign bad_type_o   = out_word.bad;

`ifndef SYNTH
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(status.halted))
    else $error("halt flag cleared without reset");

  a_bad_is_rejected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_type_o |-> byte_role_o == ROLE_REJ && frame_kind_o == KIND_NONE)
    else $error("bad type word not marked as rejected");

  a_end_not_rejected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> byte_role_o != ROLE_REJ && !bad_type_o)
    else $error("frame end on a rejected word");

  a_halted_rejects : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && status.halted |=> out_valid_o)
    else $error("word lost while halted");

  a_phase_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.phase == PH_TYPE || status.phase == PH_LEN || status.phase == PH_PAY)
    else $error("parser phase left its legal codes");
`endif

endmodule
